// ===== sv/rsame_pkg.sv =====
// Package for the modular exponentiation block: sizes, register indexes,
// controller states, datapath command and status records and the key set.
// Depends on nothing; every other file of the block imports it.
package rsame_pkg;

	localparam int WORD_BITS      = 32;
	localparam int MOD_BITS       = 32;
	localparam int SYMBOL_BITS    = 16;
	localparam int CNT_BITS       = $clog2(WORD_BITS);
	localparam int REG_ADDR_BITS  = 4;
	localparam int REG_INDEX_BITS = 2;

	localparam logic [WORD_BITS-1:0] SYMBOL_MASK =
		WORD_BITS'((64'd1 << SYMBOL_BITS) - 64'd1);

	localparam logic [REG_INDEX_BITS-1:0] REG_PEER_EXPONENT = 2'd0;
	localparam logic [REG_INDEX_BITS-1:0] REG_PEER_MODULUS  = 2'd1;
	localparam logic [REG_INDEX_BITS-1:0] REG_OWN_EXPONENT  = 2'd2;
	localparam logic [REG_INDEX_BITS-1:0] REG_OWN_MODULUS   = 2'd3;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_REDUCE,
		ST_BIT,
		ST_MUL,
		ST_SQR,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_MUL,
		OP_SQR
	} op_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] peer_exponent;
		logic [WORD_BITS-1:0] peer_modulus;
		logic [WORD_BITS-1:0] own_exponent;
		logic [WORD_BITS-1:0] own_modulus;
	} keys_t;

	typedef struct packed {
		logic load;
		logic start;
		op_t  op;
		logic exp_shift;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic exp_zero;
		logic exp_bit0;
		logic exp_rest_zero;
		logic out_free;
	} dp_stat_t;

	// A modulus register of zero stands for 2^MOD_BITS; bits above MOD_BITS are ignored.
	function automatic logic [MOD_BITS:0] effective_modulus(input logic [WORD_BITS-1:0] r);
		logic [MOD_BITS-1:0] low;
		low = r[MOD_BITS-1:0];
		return (low == '0) ? {1'b1, {MOD_BITS{1'b0}}} : {1'b0, low};
	endfunction

endpackage

// ===== sv/rsame_regs.sv =====
// Configuration register file with its APB-style slave port.
// Holds both key pairs; depends on rsame_pkg.
module rsame_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rsame_pkg::REG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output rsame_pkg::keys_t                    keys
);
	import rsame_pkg::*;

	logic [REG_INDEX_BITS-1:0] index;
	logic                      wr_en;
	keys_t                     keys_q;

	assign index  = paddr[REG_ADDR_BITS-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign keys   = keys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q.peer_exponent <= '0;
			keys_q.peer_modulus  <= WORD_BITS'(1);
			keys_q.own_exponent  <= '0;
			keys_q.own_modulus   <= WORD_BITS'(1);
		end else if (wr_en) begin
			case (index)
				REG_PEER_EXPONENT: keys_q.peer_exponent <= pwdata;
				REG_PEER_MODULUS:  keys_q.peer_modulus  <= pwdata;
				REG_OWN_EXPONENT:  keys_q.own_exponent  <= pwdata;
				REG_OWN_MODULUS:   keys_q.own_modulus   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (index)
			REG_PEER_EXPONENT: prdata = keys_q.peer_exponent;
			REG_PEER_MODULUS:  prdata = keys_q.peer_modulus;
			REG_OWN_EXPONENT:  prdata = keys_q.own_exponent;
			REG_OWN_MODULUS:   prdata = keys_q.own_modulus;
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== sv/rsame_modmul.sv =====
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
// Needs b no larger than m; depends on rsame_pkg.
module rsame_modmul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [rsame_pkg::WORD_BITS-1:0]      a,
	input  logic [rsame_pkg::MOD_BITS-1:0]       b,
	input  logic [rsame_pkg::MOD_BITS:0]         m,
	output logic                                 done,
	output logic [rsame_pkg::MOD_BITS-1:0]       product
);
	import rsame_pkg::*;

	logic [WORD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0]  b_q;
	logic [MOD_BITS-1:0]  r_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [MOD_BITS+1:0]  t;
	logic [MOD_BITS+1:0]  m1;
	logic [MOD_BITS+1:0]  m2;
	logic [MOD_BITS+1:0]  r_next;

	// With r below m and b at most m, the partial sum stays below 3m.
	always_comb begin
		m1 = (MOD_BITS+2)'(m);
		m2 = m1 << 1;
		t  = ((MOD_BITS+2)'(r_q) << 1) +
		     (a_q[WORD_BITS-1] ? (MOD_BITS+2)'(b_q) : '0);
		if (t >= m2) begin
			r_next = t - m2;
		end else if (t >= m1) begin
			r_next = t - m1;
		end else begin
			r_next = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(WORD_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q << 1;
			r_q <= r_next[MOD_BITS-1:0];
		end
	end

	assign done    = done_q;
	assign product = r_q;

endmodule

// ===== sv/rsame_datapath.sv =====
// Datapath: item and key capture, exponent shifter, accumulator and base
// registers, the shared modular multiplier and the output register.
// Depends on rsame_pkg and rsame_modmul.
module rsame_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rsame_pkg::keys_t                keys,
	input  logic                            cmd,
	input  logic [rsame_pkg::WORD_BITS-1:0] operand_value,
	input  rsame_pkg::dp_cmd_t              ctl,
	output rsame_pkg::dp_stat_t             stat,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [rsame_pkg::WORD_BITS-1:0] result_value,
	output logic                            too_wide
);
	import rsame_pkg::*;

	logic                 mode_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [MOD_BITS:0]    mod_q;
	logic [WORD_BITS-1:0] value_q;
	logic [MOD_BITS-1:0]  base_q;
	logic [MOD_BITS-1:0]  acc_q;
	op_t                  op_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] result_q;
	logic                 too_wide_q;

	logic [WORD_BITS-1:0] mul_a;
	logic [MOD_BITS-1:0]  mul_b;
	logic                 mul_done;
	logic [MOD_BITS-1:0]  mul_p;
	logic [WORD_BITS-1:0] acc_word;
	logic                 acc_wide;

	// The reduction of the operand is a product with one.
	always_comb begin
		case (ctl.op)
			OP_REDUCE: begin
				mul_a = value_q;
				mul_b = MOD_BITS'(1);
			end
			OP_MUL: begin
				mul_a = WORD_BITS'(acc_q);
				mul_b = base_q;
			end
			OP_SQR: begin
				mul_a = WORD_BITS'(base_q);
				mul_b = base_q;
			end
			default: begin
				mul_a = value_q;
				mul_b = MOD_BITS'(1);
			end
		endcase
	end

	rsame_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.start),
		.a       (mul_a),
		.b       (mul_b),
		.m       (mod_q),
		.done    (mul_done),
		.product (mul_p)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q  <= cmd;
			acc_q   <= MOD_BITS'(1);
			if (cmd == CMD_DECRYPT) begin
				exp_q   <= keys.own_exponent;
				mod_q   <= effective_modulus(keys.own_modulus);
				value_q <= operand_value;
			end else begin
				exp_q   <= keys.peer_exponent;
				mod_q   <= effective_modulus(keys.peer_modulus);
				value_q <= operand_value & SYMBOL_MASK;
			end
		end else begin
			if (ctl.exp_shift) begin
				exp_q <= exp_q >> 1;
			end
			if (mul_done) begin
				case (op_q)
					OP_MUL:  acc_q  <= mul_p;
					default: base_q <= mul_p;
				endcase
			end
		end
		if (ctl.start) begin
			op_q <= ctl.op;
		end
	end

	assign acc_word = WORD_BITS'(acc_q);
	assign acc_wide = (acc_word >> SYMBOL_BITS) != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			if (mode_q == CMD_DECRYPT && acc_wide) begin
				result_q   <= '0;
				too_wide_q <= 1'b1;
			end else begin
				result_q   <= acc_word;
				too_wide_q <= 1'b0;
			end
		end
	end

	assign stat.mul_done      = mul_done;
	assign stat.exp_zero      = (exp_q == '0);
	assign stat.exp_bit0      = exp_q[0];
	assign stat.exp_rest_zero = (exp_q[WORD_BITS-1:1] == '0);
	assign stat.out_free      = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign too_wide     = too_wide_q;

endmodule

// ===== sv/rsame_ctrl.sv =====
// Sequencer for square and multiply: orders the operand reduction, the
// multiplies and squarings and the hand-over to the output register.
// Depends on rsame_pkg.
module rsame_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rsame_pkg::dp_stat_t stat,
	output rsame_pkg::dp_cmd_t  ctl
);
	import rsame_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctl.load      = 1'b0;
		ctl.start     = 1'b0;
		ctl.op        = OP_REDUCE;
		ctl.exp_shift = 1'b0;
		ctl.out_load  = 1'b0;
		in_stall      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (stat.exp_zero) begin
					state_d = ST_FINISH;
				end else begin
					ctl.start = 1'b1;
					ctl.op    = OP_REDUCE;
					state_d   = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (stat.mul_done) begin
					state_d = ST_BIT;
				end
			end
			ST_BIT: begin
				ctl.start = 1'b1;
				if (stat.exp_bit0) begin
					ctl.op  = OP_MUL;
					state_d = ST_MUL;
				end else begin
					ctl.op        = OP_SQR;
					ctl.exp_shift = 1'b1;
					state_d       = ST_SQR;
				end
			end
			ST_MUL: begin
				if (stat.mul_done) begin
					if (stat.exp_rest_zero) begin
						state_d = ST_FINISH;
					end else begin
						ctl.start     = 1'b1;
						ctl.op        = OP_SQR;
						ctl.exp_shift = 1'b1;
						state_d       = ST_SQR;
					end
				end
			end
			ST_SQR: begin
				if (stat.mul_done) begin
					state_d = ST_BIT;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/rsa_modexp_encrypt_decrypt.sv =====
// Top level of the modular exponentiation block (square and multiply).
// Joins the register file, the sequencer and the datapath; depends on
// rsame_pkg, rsame_regs, rsame_ctrl and rsame_datapath.
//
//   Channel  Handshake            Payload
//   -------  -------------------  --------------------------------
//   input    in_valid / in_stall  cmd, operand_value
//   output   out_valid/out_stall  result_value, too_wide
//   config   APB psel/penable     paddr, pwdata, prdata (pready high)
//
// An item is worked through by passes of the bit-serial modular multiplier, which
// handles one multiplier bit a cycle: one pass reduces the operand, then one
// per set exponent bit and one squaring per exponent bit below the highest
// set bit; a zero exponent needs no pass at all.
// After reset the block is idle at once and there is no clearing pass.
// in_stall is high while an item is at work; a result that waits on
// out_stall holds the next result back, but not the next item's intake.
//
// Configuration registers sit at byte addresses 0 (peer exponent),
// 4 (peer modulus), 8 (own exponent) and 12 (own modulus); the moduli reset to 1 and the
// exponents to 0. They must be written only while idle; the block does not enforce it.
module rsa_modexp_encrypt_decrypt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rsame_pkg::REG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic [rsame_pkg::WORD_BITS-1:0]     operand_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rsame_pkg::WORD_BITS-1:0]     result_value,
	output logic                                too_wide
);
	import rsame_pkg::*;

	keys_t    keys;
	dp_cmd_t  ctl;
	dp_stat_t stat;

	// Register file: both key pairs, read back through prdata.
	rsame_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.keys    (keys)
	);

	// The sequencer sees only status flags and in_valid, and drives only commands and in_stall.
	rsame_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	// The datapath captures the beat when the sequencer loads it, and the
	// output register inside it parts the result from the next item's work.
	rsame_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.keys          (keys),
		.cmd           (cmd),
		.operand_value (operand_value),
		.ctl           (ctl),
		.stat          (stat),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.result_value  (result_value),
		.too_wide      (too_wide)
	);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rsa_modexp_encrypt_decrypt: drives command beats and keys,
// predicts every modular power in-house and checks each result beat against it.
// Depends on rsame_pkg and the block's top level only.
module tb_top;
	import rsame_pkg::*;

	// The limit covers every beat taking as long as the slowest item, with both sides idling
	// at their worst and the long receiver hold, several times over.
	localparam int unsigned CYCLE_LIMIT   = 3_000_000;
	localparam int unsigned HOLD_CYCLES   = 4000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PRINT_CAP     = 200;

	// One command beat waiting to be offered, with the gap that precedes it. A beat marked
	// drain is held back until every result already owed has come out.
	typedef struct {
		logic                 op;
		logic [WORD_BITS-1:0] operand;
		int unsigned          gap;
		bit                   drain;
	} modexp_job_t;

	// What one result beat should carry.
	typedef struct packed {
		logic [WORD_BITS-1:0] value;
		logic                 wide;
	} power_beat_t;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     psel          = 1'b0;
	logic                     penable       = 1'b0;
	logic                     pwrite        = 1'b0;
	logic [REG_ADDR_BITS-1:0] paddr         = '0;
	logic [31:0]              pwdata        = '0;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     in_valid      = 1'b0;
	logic                     in_stall;
	logic                     cmd           = CMD_ENCRYPT;
	logic [WORD_BITS-1:0]     operand_value = '0;
	logic                     out_valid;
	logic                     out_stall     = 1'b0;
	logic [WORD_BITS-1:0]     result_value;
	logic                     too_wide;

	rsa_modexp_encrypt_decrypt dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.operand_value(operand_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.too_wide     (too_wide)
	);

	always #2 clk = ~clk;

	// Beats still to be offered, and powers predicted for accepted beats, oldest first.
	modexp_job_t jobs_waiting[$];
	power_beat_t awaited_powers[$];

	// The bench's own copy of the key registers, updated as each write completes.
	logic [WORD_BITS-1:0] peer_exp_key = '0;
	logic [WORD_BITS-1:0] peer_mod_key = 'd1;
	logic [WORD_BITS-1:0] own_exp_key  = '0;
	logic [WORD_BITS-1:0] own_mod_key  = 'd1;

	// The predictor's working state, left as it stands after the last beat it handled.
	logic [WORD_BITS-1:0] pw_acc  = 'd1;
	logic [WORD_BITS-1:0] pw_base = '0;
	logic [WORD_BITS-1:0] pw_exp  = '0;
	logic                 pw_mode = CMD_ENCRYPT;

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned gap_count      = 0;
	int unsigned recv_wait      = 0;
	int unsigned hold_left      = 0;
	int unsigned hold_tickets   = 0;
	int unsigned hold_served    = 0;
	// While calm is set, neither side draws random idle gaps, giving stretches of back-to-back beats.
	bit          calm           = 1'b0;

	// Square and multiply from the least significant exponent bit. Every product is taken
	// in 64 bits and reduced by the effective modulus. A zero exponent leaves the
	// accumulator at one, unreduced even when the modulus is one.
	function automatic power_beat_t predict_power(input logic op,
			input logic [WORD_BITS-1:0] operand);
		logic [WORD_BITS-1:0] mod_reg;
		logic [63:0]          modulus;
		power_beat_t          beat;
		pw_mode = op;
		pw_base = operand;
		if (op == CMD_ENCRYPT) begin
			// Only the low symbol bits of a plaintext take part.
			pw_base = operand & SYMBOL_MASK;
			pw_exp  = peer_exp_key;
			mod_reg = peer_mod_key;
		end else begin
			pw_exp  = own_exp_key;
			mod_reg = own_mod_key;
		end
		// Bits above MOD_BITS are ignored, and a modulus of zero stands for 2^MOD_BITS.
		modulus = {32'd0, mod_reg} & ((64'd1 << MOD_BITS) - 64'd1);
		if (modulus == 64'd0) begin
			modulus = 64'd1 << MOD_BITS;
		end
		pw_acc = 'd1;
		for (int k = 0; k < WORD_BITS && pw_exp != '0; k++) begin
			if (pw_exp[0]) begin
				pw_acc = WORD_BITS'(({32'd0, pw_base} * {32'd0, pw_acc}) % modulus);
			end
			pw_exp  = pw_exp >> 1;
			pw_base = WORD_BITS'(({32'd0, pw_base} * {32'd0, pw_base}) % modulus);
		end
		beat.value = pw_acc;
		beat.wide  = 1'b0;
		// A decrypted symbol that does not fit in SYMBOL_BITS is zeroed and flagged.
		if (op == CMD_DECRYPT && (pw_acc >> SYMBOL_BITS) != '0) begin
			beat.value = '0;
			beat.wide  = 1'b1;
		end
		return beat;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP) begin
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		end
	endtask

	// Free-running cycle count; a run that overstays the limit is a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Command driver. A beat is accepted at an edge with in_valid high and in_stall low, and
	// its power is predicted there from the keys then in force. in_valid gets exactly one
	// nonblocking assignment per edge, so a beat that follows with no gap keeps it high.
	always @(posedge clk or negedge arst_n) begin : drive_commands
		modexp_job_t job;
		logic        offer;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			cmd           <= CMD_ENCRYPT;
			operand_value <= '0;
			gap_count = 0;
		end else begin
			offer = in_valid;
			if (in_valid && !in_stall) begin
				awaited_powers.push_back(predict_power(cmd, operand_value));
				offer = 1'b0;
			end
			if (!offer && jobs_waiting.size() != 0) begin
				job = jobs_waiting[0];
				if (job.drain && awaited_powers.size() != 0) begin
					// Sender pauses here until the block has handed back everything owed.
				end else if (gap_count < job.gap) begin
					gap_count++;
				end else begin
					job = jobs_waiting.pop_front();
					cmd           <= job.op;
					operand_value <= job.operand;
					offer     = 1'b1;
					gap_count = 0;
				end
			end
			in_valid <= offer;
		end
	end

	// Result monitor and receiver. Each accepted result beat is compared field by field
	// with the oldest prediction, after which the receiver draws how long it stalls. A
	// hold ticket from the stimulus makes it hold off for a long stretch, counted here, so
	// that the block fills and pushes back on its input.
	always @(posedge clk or negedge arst_n) begin : collect_results
		power_beat_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_powers.size() == 0) begin
					report_mismatch($sformatf("result beat %h with nothing owed", result_value));
				end else begin
					want = awaited_powers.pop_front();
					if (result_value !== want.value) begin
						report_mismatch($sformatf("result_value %h, predicted %h",
							result_value, want.value));
					end
					if (too_wide !== want.wide) begin
						report_mismatch($sformatf("too_wide %b, predicted %b",
							too_wide, want.wide));
					end
				end
				recv_wait = calm ? 0 : $urandom_range(0, 10);
			end else if (recv_wait != 0) begin
				recv_wait--;
			end
			if (hold_served != hold_tickets) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end else if (hold_left != 0) begin
				hold_left--;
			end
			out_stall <= (recv_wait != 0) || (hold_left != 0);
		end
	end

	// Keys may only change while the block is idle. Idleness is judged on the falling edge,
	// once every update of the rising edge has settled.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (jobs_waiting.size() != 0 || in_valid || awaited_powers.size() != 0);
	endtask

	// One register write: a setup phase, then an access phase that completes on pready.
	task automatic reg_write(input logic [REG_INDEX_BITS-1:0] idx,
			input logic [WORD_BITS-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PEER_EXPONENT: peer_exp_key = value;
			REG_PEER_MODULUS:  peer_mod_key = value;
			REG_OWN_EXPONENT:  own_exp_key  = value;
			REG_OWN_MODULUS:   own_mod_key  = value;
			default: ;
		endcase
	endtask

	task automatic set_keys(input logic [WORD_BITS-1:0] peer_exp, peer_mod, own_exp, own_mod);
		wait_idle();
		reg_write(REG_PEER_EXPONENT, peer_exp);
		reg_write(REG_PEER_MODULUS, peer_mod);
		reg_write(REG_OWN_EXPONENT, own_exp);
		reg_write(REG_OWN_MODULUS, own_mod);
	endtask

	task automatic queue_job(input logic op, input logic [WORD_BITS-1:0] operand,
			input bit drain);
		modexp_job_t job;
		job.op      = op;
		job.operand = operand;
		job.gap     = calm ? 0 : $urandom_range(0, 10);
		job.drain   = drain;
		jobs_waiting.push_back(job);
	endtask

	// Exponents of a random width, so that most items stay short; now and then zero or
	// all ones of that width.
	function automatic logic [WORD_BITS-1:0] draw_exponent(input int unsigned max_bits);
		int unsigned          bits;
		logic [WORD_BITS-1:0] mask;
		bits = $urandom_range(0, max_bits);
		mask = WORD_BITS'((64'd1 << bits) - 64'd1);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return mask;
			default: return $urandom & mask;
		endcase
	endfunction

	// Moduli of zero and one, the largest, ones small enough for decrypted symbols to fit,
	// ones just too large for that, and wholly random ones.
	function automatic logic [WORD_BITS-1:0] draw_modulus();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 'd1;
			2:       return '1;
			3, 4, 5: return $urandom_range(2, 32'h0001_0000);
			6, 7:    return $urandom_range(32'h0001_0001, 32'h000F_FFFF);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [WORD_BITS-1:0] draw_operand();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom_range(0, 32'h0000_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// A phase of random beats under fresh random keys. In a squeezed phase the receiver
	// holds off for a long stretch while the sender keeps offering back-to-back beats.
	// Halfway through each phase the sender waits until every result has come out.
	task automatic run_random_phase(input int n_jobs, input int unsigned exp_bits,
			input bit quiet, input bit squeeze);
		set_keys(draw_exponent(exp_bits), draw_modulus(), draw_exponent(exp_bits),
			draw_modulus());
		calm = quiet;
		if (squeeze) begin
			hold_tickets++;
		end
		for (int k = 0; k < n_jobs; k++) begin
			queue_job(($urandom_range(0, 1) == 0) ? CMD_ENCRYPT : CMD_DECRYPT,
				draw_operand(), k == n_jobs / 2);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Keys as they come out of reset: both exponents are zero, so every power is an
		// unreduced one even though both moduli are one.
		queue_job(CMD_ENCRYPT, '1, 1'b0);
		queue_job(CMD_DECRYPT, '1, 1'b0);

		// A common public exponent over a zero modulus, which reduces to the low word, and
		// the largest exponent and modulus for decrypting. Encrypt plaintexts lose their
		// upper half; a decrypt operand equal to the modulus reduces to nothing.
		set_keys(32'h0001_0001, '0, '1, '1);
		queue_job(CMD_ENCRYPT, 32'h0000_FFFF, 1'b0);
		queue_job(CMD_ENCRYPT, 32'hFFFF_0000, 1'b0);
		queue_job(CMD_ENCRYPT, 32'h1234_5678, 1'b0);
		queue_job(CMD_DECRYPT, '0, 1'b0);
		queue_job(CMD_DECRYPT, '1, 1'b0);
		queue_job(CMD_DECRYPT, 32'd1, 1'b0);
		queue_job(CMD_DECRYPT, 32'd2, 1'b0);

		// An encrypt modulus of one sends every power to zero. Decrypting with exponent one
		// over 2^16 + 1 puts a symbol just too wide and one just fitting side by side.
		set_keys(32'd3, 32'd1, 32'd1, 32'h0001_0001);
		queue_job(CMD_ENCRYPT, '0, 1'b0);
		queue_job(CMD_ENCRYPT, '1, 1'b0);
		queue_job(CMD_DECRYPT, 32'h0001_0000, 1'b0);
		queue_job(CMD_DECRYPT, 32'h0000_FFFF, 1'b0);
		queue_job(CMD_DECRYPT, '1, 1'b0);

		// Only the top exponent bit set, for the longest run of squarings; squaring over a
		// zero decrypt modulus wraps at 2^32, which turns one large operand into zero.
		set_keys(32'h8000_0000, 32'hFFFF_FFFB, 32'd2, '0);
		queue_job(CMD_ENCRYPT, 32'd2, 1'b0);
		queue_job(CMD_ENCRYPT, 32'h0000_FFFF, 1'b0);
		queue_job(CMD_DECRYPT, '1, 1'b0);
		queue_job(CMD_DECRYPT, 32'h0001_0000, 1'b0);
		queue_job(CMD_DECRYPT, 32'h0000_0100, 1'b0);

		run_random_phase(40, 12, 1'b0, 1'b0);
		run_random_phase(24, 6, 1'b1, 1'b1);
		run_random_phase(32, 32, 1'b0, 1'b0);
		run_random_phase(32, 10, 1'b1, 1'b0);
		run_random_phase(32, 16, 1'b0, 1'b0);
		run_random_phase(32, 8, 1'b0, 1'b0);
		run_random_phase(32, 32, 1'b0, 1'b0);
		run_random_phase(32, 12, 1'b0, 1'b0);

		// Let the last results drain, then give any stray beat time to show itself.
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/rsame_pkg.sv
sv/rsame_regs.sv
sv/rsame_modmul.sv
sv/rsame_datapath.sv
sv/rsame_ctrl.sv
sv/rsa_modexp_encrypt_decrypt.sv
bench/tb_top.sv
